[rtl/core/yprgb_pkg.sv]
package yprgb_pkg;

   localparam int PixW     = 8;
   localparam int GainW    = 9;
   localparam int FracBits = 16;
   localparam int CoefW    = 18;
   localparam int ProdW    = 28;
   localparam int TermW    = 9;

   localparam logic [GainW-1:0] GainReset = 9'd220;

   localparam logic signed [CoefW-1:0] CoefRCr = 18'sd89831;
   localparam logic signed [CoefW-1:0] CoefGCr = 18'sd45744;
   localparam logic signed [CoefW-1:0] CoefGCb = 18'sd22127;
   localparam logic signed [CoefW-1:0] CoefBCb = 18'sd113538;

   typedef struct packed {
      logic [PixW-1:0] luma_first;
      logic [PixW-1:0] chroma_blue;
      logic [PixW-1:0] luma_second;
      logic [PixW-1:0] chroma_red;
      logic            last_pair;
   } yuyv_word_type;

   typedef struct packed {
      logic [PixW-1:0] red_first;
      logic [PixW-1:0] green_first;
      logic [PixW-1:0] blue_first;
      logic [PixW-1:0] red_second;
      logic [PixW-1:0] green_second;
      logic [PixW-1:0] blue_second;
      logic            frame_end;
   } rgb_word_type;

   typedef struct packed {
      logic signed [TermW-1:0] red;
      logic signed [TermW-1:0] green;
      logic signed [TermW-1:0] blue;
   } chroma_terms_type;

endpackage

[rtl/core/yprgb_chroma.sv]
module yprgb_chroma
   import yprgb_pkg::*;
(
   input  logic [PixW-1:0] chroma_blue,
   input  logic [PixW-1:0] chroma_red,
   output chroma_terms_type terms
);

   logic signed [PixW-1:0]  dcb;
   logic signed [PixW-1:0]  dcr;
   logic signed [ProdW-1:0] r_prod;
   logic signed [ProdW-1:0] g_prod;
   logic signed [ProdW-1:0] b_prod;

   // Removing the offset of 128 from a byte is an inversion of its top bit.
   assign dcb = {~chroma_blue[PixW-1], chroma_blue[PixW-2:0]};
   assign dcr = {~chroma_red[PixW-1], chroma_red[PixW-2:0]};

   assign r_prod = ProdW'(CoefRCr) * ProdW'(dcr);
   assign g_prod = -(ProdW'(CoefGCr) * ProdW'(dcr)) - ProdW'(CoefGCb) * ProdW'(dcb);
   assign b_prod = ProdW'(CoefBCb) * ProdW'(dcb);

   // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
   assign terms.red   = r_prod[FracBits+TermW-1:FracBits];
   assign terms.green = g_prod[FracBits+TermW-1:FracBits];
   assign terms.blue  = b_prod[FracBits+TermW-1:FracBits];

endmodule

[rtl/core/yuyv_pair_to_rgb24.sv]
// YUYV 4:2:2 to RGB888 converter, one packed group of two pixels per word.
// The request channel (req_valid, req_ready, req_data) carries one YUYV group:
// two luma bytes, a shared Cb and a shared Cr byte, and a last flag. The
// response channel (rsp_valid, rsp_ready, rsp_data) returns the two RGB pixels
// of that group, each channel clamped to 0..255 and scaled by the gain register/256,
// with the last flag copied to frame_end.
// The gain register is written when csr_wr_en is high and resets to 220.
// The datapath is a four-register pipeline: input register, chroma products,
// clamped channels, scaled output register. A word accepted into the input
// register passes through each later register in turn before it appears on rsp_data.
// Throughput is one word per clock as long as rsp_ready stays high.
// When the receiver stalls, words fill the empty pipeline registers and
// req_ready drops only once every stage holds a word.
// Reset empties the pipeline and restores the gain; no words are lost or
// repeated across a stall.
module yuyv_pair_to_rgb24
   import yprgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  yuyv_word_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rgb_word_type  rsp_data,
   input  logic          csr_wr_en,
   input  logic [GainW-1:0] csr_wr_data
);

   localparam int Stages = 4;
   localparam int WholeW = TermW + 2;
   localparam int ScaleW = PixW + GainW;

   logic [GainW-1:0]  gain_ff;
   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] adv;

   yuyv_word_type     in_ff;
   chroma_terms_type  terms_in;
   chroma_terms_type  terms_ff;
   logic [PixW-1:0]   luma1_ff;
   logic [PixW-1:0]   luma2_ff;
   logic              last_b_ff;
   rgb_word_type      clamp_in;
   rgb_word_type      clamp_ff;
   rgb_word_type      rsp_in;
   rgb_word_type      rsp_ff;

   function automatic logic [PixW-1:0] clamp_pix(logic [PixW-1:0] y,
                                                 logic signed [TermW-1:0] t);
      logic signed [WholeW-1:0] whole;
      whole = $signed({{(WholeW-PixW){1'b0}}, y}) + WholeW'(t);
      if (whole < 0) begin
         return '0;
      end else if (whole > $signed(WholeW'(2**PixW - 1))) begin
         return '1;
      end else begin
         return whole[PixW-1:0];
      end
   endfunction

   function automatic logic [PixW-1:0] scale_pix(logic [PixW-1:0] c,
                                                 logic [GainW-1:0] g);
      logic [ScaleW-1:0] prod;
      prod = ScaleW'(c) * ScaleW'(g);
      if (prod[ScaleW-1]) begin
         return '1;
      end else begin
         return prod[ScaleW-2:ScaleW-1-PixW];
      end
   endfunction

   yprgb_chroma u_chroma (
      .chroma_blue (in_ff.chroma_blue),
      .chroma_red  (in_ff.chroma_red),
      .terms       (terms_in)
   );

   assign adv[Stages-1] = !vld_ff[Stages-1] || rsp_ready;
   for (genvar k = 0; k < Stages - 1; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_comb begin
      clamp_in.red_first    = clamp_pix(luma1_ff, terms_ff.red);
      clamp_in.green_first  = clamp_pix(luma1_ff, terms_ff.green);
      clamp_in.blue_first   = clamp_pix(luma1_ff, terms_ff.blue);
      clamp_in.red_second   = clamp_pix(luma2_ff, terms_ff.red);
      clamp_in.green_second = clamp_pix(luma2_ff, terms_ff.green);
      clamp_in.blue_second  = clamp_pix(luma2_ff, terms_ff.blue);
      clamp_in.frame_end    = last_b_ff;

      rsp_in.red_first      = scale_pix(clamp_ff.red_first, gain_ff);
      rsp_in.green_first    = scale_pix(clamp_ff.green_first, gain_ff);
      rsp_in.blue_first     = scale_pix(clamp_ff.blue_first, gain_ff);
      rsp_in.red_second     = scale_pix(clamp_ff.red_second, gain_ff);
      rsp_in.green_second   = scale_pix(clamp_ff.green_second, gain_ff);
      rsp_in.blue_second    = scale_pix(clamp_ff.blue_second, gain_ff);
      rsp_in.frame_end      = clamp_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GainReset;
         vld_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         in_ff <= req_data;
      end
      if (adv[1]) begin
         terms_ff  <= terms_in;
         luma1_ff  <= in_ff.luma_first;
         luma2_ff  <= in_ff.luma_second;
         last_b_ff <= in_ff.last_pair;
      end
      if (adv[2]) begin
         clamp_ff <= clamp_in;
      end
      if (adv[3]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[Stages-1];
   assign rsp_data  = rsp_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("Pipeline holds a word after reset.");

   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Input stalled while the output side is ready.");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '1 && !rsp_ready) |-> !req_ready)
      else $error("Input accepted while every stage is full and stalled.");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !adv[0]) |=> vld_ff[0] && $stable(in_ff))
      else $error("Stalled input register lost its word.");

endmodule
